[src/msb_pkg.sv]
`default_nettype none

package msb_pkg;

    // Field widths of one command word and one response word.
    localparam int CMD_W    = 3;
    localparam int POS_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int AMOUNT_W = 8;
    localparam int STATUS_W = 4;
    localparam int FILL_W   = 6;

    // Width for signed size arithmetic: a capacity of up to 64 plus an 8-bit signed delta.
    localparam int SIZE_W = 10;

    typedef logic [CMD_W-1:0]           command_t;
    typedef logic [POS_W-1:0]           position_t;
    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic signed [AMOUNT_W-1:0] amount_t;
    typedef logic [STATUS_W-1:0]        status_t;
    typedef logic [FILL_W-1:0]          fill_t;

    // Command codes.
    localparam command_t CMD_CREATE = 3'd0;
    localparam command_t CMD_PUSH   = 3'd1;
    localparam command_t CMD_POP    = 3'd2;
    localparam command_t CMD_RESIZE = 3'd3;
    localparam command_t CMD_COUNT  = 3'd4;
    localparam command_t CMD_READ   = 3'd5;

    // Status codes.
    localparam status_t ST_OK       = 4'd0;
    localparam status_t ST_BAD_POS  = 4'd1;
    localparam status_t ST_EXISTS   = 4'd2;
    localparam status_t ST_BAD_SIZE = 4'd3;
    localparam status_t ST_NO_MEM   = 4'd4;
    localparam status_t ST_NO_SLOT  = 4'd5;
    localparam status_t ST_FULL     = 4'd6;
    localparam status_t ST_EMPTY    = 4'd7;
    localparam status_t ST_BAD_NEW  = 4'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic commit;
        logic rd_start;
        logic rd_issue;
        logic rd_emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic undef_cmd;
        logic stream;
        logic last_elem;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[src/msb_cmd_if.sv]
`default_nettype none

interface msb_cmd_if;
    logic                valid;
    logic                ready;
    msb_pkg::command_t   command;
    msb_pkg::position_t  position;
    msb_pkg::value_t     value;
    msb_pkg::amount_t    amount;

    modport source (output valid, command, position, value, amount, input ready);
    modport sink (input valid, command, position, value, amount, output ready);
endinterface

`default_nettype wire

[src/msb_rsp_if.sv]
`default_nettype none

interface msb_rsp_if;
    logic               valid;
    logic               ready;
    msb_pkg::status_t   status;
    msb_pkg::value_t    data_value;
    msb_pkg::fill_t     fill_count;
    logic               last;

    modport source (output valid, status, data_value, fill_count, last, input ready);
    modport sink (input valid, status, data_value, fill_count, last, output ready);
endinterface

`default_nettype wire

[src/msb_ram.sv]
`default_nettype none

module msb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 320
) (
    input  wire logic                                       clk,
    input  wire logic                                       wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                           wr_data,
    input  wire logic                                       rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[src/msb_ctrl.sv]
`default_nettype none

module msb_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire msb_pkg::dp_stat_t stat,
    output msb_pkg::ctrl_cmd_t     ctl
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_EXEC    = 2'd1;
    localparam logic [1:0] S_RD_ADDR = 2'd2;
    localparam logic [1:0] S_RD_DATA = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // Undefined commands leave without a response.
                if (stat.undef_cmd)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.stream)
                begin
                    ctl.rd_start = 1'b1;
                    state_next   = S_RD_ADDR;
                end
                else if (stat.out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD_ADDR:
            begin
                ctl.rd_issue = 1'b1;
                state_next   = S_RD_DATA;
            end
            S_RD_DATA:
            begin
                if (stat.out_free)
                begin
                    ctl.rd_emit = 1'b1;
                    state_next  = stat.last_elem ? S_IDLE : S_RD_ADDR;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Read data is only ever consumed after a read was issued for it.
    a_rd_data_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_DATA) |->
            ($past(state_reg) == S_RD_ADDR || $past(state_reg) == S_RD_DATA))
        else $error("read data state entered without a read issue");

endmodule

`default_nettype wire

[src/msb_dp.sv]
`default_nettype none

module msb_dp #(
    parameter int NUM_SLOTS    = 10,
    parameter int MAX_CAPACITY = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire msb_pkg::command_t   in_command,
    input  wire msb_pkg::position_t  in_position,
    input  wire msb_pkg::value_t     in_value,
    input  wire msb_pkg::amount_t    in_amount,
    input  wire msb_pkg::ctrl_cmd_t  ctl,
    output msb_pkg::dp_stat_t        stat,
    msb_rsp_if.source                rsp
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_CAPACITY + 1);
    localparam int DEPTH  = NUM_SLOTS * MAX_CAPACITY;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SIZE_W = msb_pkg::SIZE_W;

    localparam logic [CNT_W-1:0]         MAX_CNT  = CNT_W'(MAX_CAPACITY);
    localparam logic signed [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_CAPACITY);
    localparam logic signed [SIZE_W-1:0] ONE_SIZE = SIZE_W'(1);

    // Captured command word.
    msb_pkg::command_t  command_reg;
    msb_pkg::position_t position_reg;
    msb_pkg::value_t    value_reg;
    msb_pkg::amount_t   amount_reg;

    // Per-slot bookkeeping.
    logic [CNT_W-1:0]     count_reg [NUM_SLOTS];
    logic [CNT_W-1:0]     cap_reg   [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] exists_reg;

    logic [CNT_W-1:0] idx_reg;

    // Response register.
    logic               out_valid_reg;
    msb_pkg::status_t   status_reg;
    msb_pkg::value_t    data_reg;
    msb_pkg::fill_t     fill_reg;
    logic               last_reg;

    logic                      pos_ok;
    logic [SLOT_W-1:0]         slot_idx;
    logic                      cur_exists;
    logic [CNT_W-1:0]          cur_cnt;
    logic [CNT_W-1:0]          cur_cap;
    logic signed [SIZE_W-1:0]  amt_x;
    logic signed [SIZE_W-1:0]  cap_x;
    logic signed [SIZE_W-1:0]  ncap;
    msb_pkg::status_t          status_n;
    msb_pkg::fill_t            fill_n;
    logic                      ok_commit;
    logic [ADDR_W-1:0]         base_addr;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      wr_en;
    logic [msb_pkg::VALUE_W-1:0] rd_data;
    logic                      out_free;

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            command_reg  <= in_command;
            position_reg <= in_position;
            value_reg    <= in_value;
            amount_reg   <= in_amount;
        end
    end

    assign pos_ok     = (position_reg != '0) &&
                        ({3'b000, position_reg} <= 7'(NUM_SLOTS));
    assign slot_idx   = SLOT_W'(position_reg - 4'd1);
    assign cur_exists = pos_ok && exists_reg[slot_idx];
    assign cur_cnt    = pos_ok ? count_reg[slot_idx] : '0;
    assign cur_cap    = pos_ok ? cap_reg[slot_idx] : '0;

    assign amt_x = SIZE_W'(amount_reg);
    assign cap_x = $signed({{(SIZE_W - CNT_W){1'b0}}, cur_cap});
    assign ncap  = cap_x + amt_x;

    always_comb
    begin
        status_n = msb_pkg::ST_OK;
        if (!pos_ok)
        begin
            status_n = msb_pkg::ST_BAD_POS;
        end
        else if (command_reg == msb_pkg::CMD_CREATE)
        begin
            if (cur_exists)
            begin
                status_n = msb_pkg::ST_EXISTS;
            end
            else if (amt_x < ONE_SIZE)
            begin
                status_n = msb_pkg::ST_BAD_SIZE;
            end
            else if (amt_x > MAX_SIZE)
            begin
                status_n = msb_pkg::ST_NO_MEM;
            end
        end
        else if (!cur_exists)
        begin
            status_n = msb_pkg::ST_NO_SLOT;
        end
        else
        begin
            case (command_reg)
                msb_pkg::CMD_PUSH:
                begin
                    if (cur_cnt >= cur_cap || cur_cnt >= MAX_CNT)
                    begin
                        status_n = msb_pkg::ST_FULL;
                    end
                end
                msb_pkg::CMD_POP,
                msb_pkg::CMD_COUNT:
                begin
                    if (cur_cnt == '0)
                    begin
                        status_n = msb_pkg::ST_EMPTY;
                    end
                end
                msb_pkg::CMD_RESIZE:
                begin
                    if (ncap < ONE_SIZE)
                    begin
                        status_n = msb_pkg::ST_BAD_NEW;
                    end
                    else if (ncap > MAX_SIZE)
                    begin
                        status_n = msb_pkg::ST_NO_MEM;
                    end
                end
                default:
                begin
                    status_n = msb_pkg::ST_OK;
                end
            endcase
        end
    end

    assign fill_n = (command_reg == msb_pkg::CMD_COUNT && status_n == msb_pkg::ST_OK) ?
                    msb_pkg::FILL_W'(cur_cnt) : '0;

    assign ok_commit = ctl.commit && (status_n == msb_pkg::ST_OK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exists_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                count_reg[i] <= '0;
                cap_reg[i]   <= '0;
            end
        end
        else if (ok_commit)
        begin
            case (command_reg)
                msb_pkg::CMD_CREATE:
                begin
                    exists_reg[slot_idx] <= 1'b1;
                    count_reg[slot_idx]  <= '0;
                    cap_reg[slot_idx]    <= CNT_W'(amount_reg);
                end
                msb_pkg::CMD_PUSH:
                begin
                    count_reg[slot_idx] <= cur_cnt + 1'b1;
                end
                msb_pkg::CMD_POP:
                begin
                    count_reg[slot_idx] <= cur_cnt - 1'b1;
                end
                msb_pkg::CMD_RESIZE:
                begin
                    cap_reg[slot_idx] <= CNT_W'(ncap);
                    if (cap_x + amt_x < $signed({{(SIZE_W - CNT_W){1'b0}}, cur_cnt}))
                    begin
                        count_reg[slot_idx] <= CNT_W'(ncap);
                    end
                end
                default:
                begin
                    count_reg[slot_idx] <= cur_cnt;
                end
            endcase
        end
    end

    // Element index while a slot is streamed out.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (ctl.rd_start)
        begin
            idx_reg <= '0;
        end
        else if (ctl.rd_emit)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Each slot owns MAX_CAPACITY consecutive entries of the element memory.
    assign base_addr = ADDR_W'(slot_idx) * ADDR_W'(MAX_CAPACITY);
    assign wr_addr   = base_addr + ADDR_W'(cur_cnt);
    assign rd_addr   = base_addr + ADDR_W'(idx_reg);
    assign wr_en     = ok_commit && (command_reg == msb_pkg::CMD_PUSH);

    msb_ram #(
        .WIDTH (msb_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_elem_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value_reg),
        .rd_en   (ctl.rd_issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register: accepts a new word whenever the previous one leaves.
    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.commit || ctl.rd_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            status_reg <= status_n;
            data_reg   <= '0;
            fill_reg   <= fill_n;
            last_reg   <= 1'b1;
        end
        else if (ctl.rd_emit)
        begin
            status_reg <= msb_pkg::ST_OK;
            data_reg   <= $signed(rd_data);
            fill_reg   <= '0;
            last_reg   <= stat.last_elem;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.data_value = data_reg;
    assign rsp.fill_count = fill_reg;
    assign rsp.last       = last_reg;

    assign stat.undef_cmd = (command_reg > msb_pkg::CMD_READ);
    assign stat.stream    = (command_reg == msb_pkg::CMD_READ) && cur_exists &&
                            (cur_cnt != '0);
    assign stat.last_elem = ({1'b0, idx_reg} + 1'b1) == {1'b0, cur_cnt};
    assign stat.out_free  = out_free;

    // A stream read never goes past the slot's filled entries.
    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_issue |-> (idx_reg < cur_cnt))
        else $error("element read beyond slot count");

    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_slot_chk
        a_slot_bounds: assert property (@(posedge clk) disable iff (!rst_n)
            exists_reg[g] |->
                (count_reg[g] <= cap_reg[g]) && (cap_reg[g] != '0) &&
                (cap_reg[g] <= MAX_CNT))
            else $error("slot count or capacity out of bounds");

        a_absent_clear: assert property (@(posedge clk) disable iff (!rst_n)
            !exists_reg[g] |-> (count_reg[g] == '0) && (cap_reg[g] == '0))
            else $error("absent slot holds a count or capacity");
    end

endmodule

`default_nettype wire

[src/multi_stack_bank.sv]
// multi_stack_bank keeps NUM_SLOTS independent bounded stacks of 32-bit values, addressed by
// positions 1 to NUM_SLOTS, and executes one command word at a time: create, push, pop,
// resize, count query and read all. Every command except read all of a non-empty slot returns
// exactly one response word with its last bit set; read all returns one word per stored value,
// oldest first, with last set on the final one. Commands 6 and 7 are dropped without a response.
// A single-response command is captured, then executed with the response register written; no
// new command word is taken until it is done. Read all issues each element read to the
// registered read port of the element memory, then writes the value to the response register.
// The response register decouples the two sides: a command is taken while the previous
// response still waits, and the block only stalls when a new response must be written before
// the old one has left. No clearing pass is needed after reset.

`default_nettype none

module multi_stack_bank #(
    parameter int NUM_SLOTS    = 10,
    parameter int MAX_CAPACITY = 32
) (
    input wire logic  clk,
    input wire logic  rst_n,
    msb_cmd_if.sink   cmd,
    msb_rsp_if.source rsp
);

    // Command and status bundles between the sequencer and the datapath.
    msb_pkg::ctrl_cmd_t ctl;
    msb_pkg::dp_stat_t  stat;
    logic               in_ready;

    // The sequencer decides when a command word is taken, when its single response is written,
    // and walks the element reads of a read-all command.
    msb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    assign cmd.ready = in_ready;

    // The datapath holds the per-slot counts, capacities and presence flags, the element memory,
    // all command checks, and the response register that drives the response channel.
    msb_dp #(
        .NUM_SLOTS    (NUM_SLOTS),
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_command  (cmd.command),
        .in_position (cmd.position),
        .in_value    (cmd.value),
        .in_amount   (cmd.amount),
        .ctl         (ctl),
        .stat        (stat),
        .rsp         (rsp)
    );

endmodule

`default_nettype wire
